### rtl/core/flps_pkg.sv
// flps_pkg: shared types, register map and helpers for the four-LED pwm selector
// depends on nothing; imported by every module under rtl/core
package flps_pkg;

	localparam int DUTY_W = 8;
	localparam int GAP_W  = 16;
	localparam int CD_W   = 17;

	localparam logic [15:0] GAP_RST   = 16'd250;
	localparam logic [7:0]  BASE_RST  = 8'd10;
	localparam logic [7:0]  WRAP_RST  = 8'd9;
	localparam logic [15:0] EXTRA_RST = 16'd100;

	typedef enum logic [1:0] {
		REG_GAP   = 2'd0,
		REG_BASE  = 2'd1,
		REG_WRAP  = 2'd2,
		REG_EXTRA = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [GAP_W-1:0]  gap;
		logic [DUTY_W-1:0] base;
		logic [DUTY_W-1:0] wrap;
		logic [15:0]       extra;
	} cfg_t;

	// one setting handed to an LED lane
	typedef struct packed {
		logic              valid;
		logic [DUTY_W-1:0] duty;
		logic              blink;
	} post_t;

	// dark ticks of one period
	function automatic logic [CD_W-1:0] off_len(input logic [DUTY_W-1:0] duty,
		input logic blink, input logic [DUTY_W-1:0] base, input logic [15:0] extra);
		logic [DUTY_W-1:0] base_off;
		base_off = (base > duty) ? (base - duty) : '0;
		return {{(CD_W-DUTY_W){1'b0}}, base_off} + (blink ? {1'b0, extra} : {CD_W{1'b0}});
	endfunction

endpackage

### rtl/core/flps_cfg.sv
// flps_cfg: apb register file for gap, base period, duty wrap and blink extra
// depends on flps_pkg
module flps_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output flps_pkg::cfg_t     cfg,
	output logic               wrap_wr
);
	import flps_pkg::*;

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready  = 1'b1;
	assign idx     = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel & penable & pwrite & pready;
	assign wrap_wr = wr_en && (idx == REG_WRAP);
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap   <= GAP_RST;
			cfg_q.base  <= BASE_RST;
			cfg_q.wrap  <= WRAP_RST;
			cfg_q.extra <= EXTRA_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_GAP:   cfg_q.gap   <= pwdata[15:0];
				REG_BASE:  cfg_q.base  <= pwdata[7:0];
				REG_WRAP:  cfg_q.wrap  <= pwdata[7:0];
				REG_EXTRA: cfg_q.extra <= pwdata[15:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_GAP:   prdata = {16'd0, cfg_q.gap};
			REG_BASE:  prdata = {24'd0, cfg_q.base};
			REG_WRAP:  prdata = {24'd0, cfg_q.wrap};
			REG_EXTRA: prdata = {16'd0, cfg_q.extra};
			default:   prdata = '0;
		endcase
	end

endmodule

### rtl/core/flps_ctrl.sv
// flps_ctrl: button debounce, led selection, duty stepping and posting of settings
// also holds the duty residues and the bit-serial sweep that renormalizes them
// depends on flps_pkg
module flps_ctrl #(
	parameter int NUM_LEDS = 4,
	parameter int SEL_W    = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                fire,
	input  logic                                button_irq,
	input  logic                                select_pressed,
	input  logic                                step_pressed,
	input  flps_pkg::cfg_t                      cfg,
	input  logic                                wrap_wr,
	input  logic [NUM_LEDS-1:0]                 act_blink,
	output flps_pkg::post_t [NUM_LEDS-1:0]      posts,
	output logic [SEL_W-1:0]                    sel_next,
	output logic                                busy
);
	import flps_pkg::*;

	localparam logic [SEL_W-1:0] LAST = SEL_W'(NUM_LEDS - 1);

	logic [GAP_W-1:0]  sel_since_q, stp_since_q;
	logic [GAP_W-1:0]  sel_since_d, stp_since_d;
	logic [SEL_W-1:0]  sel_q;
	logic [DUTY_W-1:0] duty_q [NUM_LEDS];
	logic [DUTY_W-1:0] res_q  [NUM_LEDS];
	logic [DUTY_W-1:0] duty_d [NUM_LEDS];
	logic [DUTY_W-1:0] res_sw [NUM_LEDS];
	logic              sel_hit, stp_hit;
	logic [DUTY_W-1:0] step_val;
	logic [DUTY_W:0]   res_inc;
	logic              busy_q;
	logic [2:0]        bit_q;

	assign busy = busy_q;

	always_comb begin
		sel_hit  = button_irq & select_pressed & (sel_since_q >= cfg.gap);
		stp_hit  = button_irq & step_pressed & (stp_since_q >= cfg.gap);
		sel_next = sel_hit ? ((sel_q == LAST) ? '0 : sel_q + 1'b1) : sel_q;
		// residue is duty mod wrap, so the wrap check is a single compare
		res_inc  = {1'b0, res_q[sel_next]} + 1'b1;
		if (cfg.wrap == '0 || res_inc == {1'b0, cfg.wrap})
			step_val = '0;
		else
			step_val = res_inc[DUTY_W-1:0];
		sel_since_d = sel_hit ? GAP_W'(1) :
			((sel_since_q == '1) ? sel_since_q : sel_since_q + 1'b1);
		stp_since_d = stp_hit ? GAP_W'(1) :
			((stp_since_q == '1) ? stp_since_q : stp_since_q + 1'b1);
	end

	always_comb begin
		for (int k = 0; k < NUM_LEDS; k++) begin
			posts[k]  = '0;
			duty_d[k] = duty_q[k];
			if (sel_hit && sel_q == SEL_W'(k))
				posts[k] = '{valid: 1'b1, duty: duty_q[k], blink: 1'b0};
			if (sel_hit && sel_next == SEL_W'(k))
				posts[k] = '{valid: 1'b1, duty: duty_q[k], blink: 1'b1};
			if (stp_hit && sel_next == SEL_W'(k)) begin
				posts[k]  = '{valid: 1'b1, duty: step_val, blink: act_blink[k]};
				duty_d[k] = step_val;
			end
		end
	end

	// restoring remainder, one duty bit per cycle, all lanes at once
	always_comb begin
		for (int k = 0; k < NUM_LEDS; k++) begin
			logic [DUTY_W:0] t;
			t = {res_q[k], duty_q[k][bit_q]};
			if (t >= {1'b0, cfg.wrap})
				t = t - {1'b0, cfg.wrap};
			res_sw[k] = t[DUTY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_since_q <= '0;
			stp_since_q <= '0;
			sel_q       <= '0;
			busy_q      <= 1'b0;
			bit_q       <= '0;
			for (int k = 0; k < NUM_LEDS; k++) begin
				duty_q[k] <= '0;
				res_q[k]  <= '0;
			end
		end else if (wrap_wr) begin
			busy_q <= 1'b1;
			bit_q  <= 3'd7;
			for (int k = 0; k < NUM_LEDS; k++)
				res_q[k] <= '0;
		end else if (busy_q) begin
			for (int k = 0; k < NUM_LEDS; k++)
				res_q[k] <= res_sw[k];
			bit_q <= bit_q - 1'b1;
			if (bit_q == '0)
				busy_q <= 1'b0;
		end else if (fire) begin
			sel_since_q <= sel_since_d;
			stp_since_q <= stp_since_d;
			sel_q       <= sel_next;
			for (int k = 0; k < NUM_LEDS; k++) begin
				duty_q[k] <= duty_d[k];
				if (stp_hit && sel_next == SEL_W'(k))
					res_q[k] <= step_val;
			end
		end
	end

`ifndef SYNTHESIS
	a_sel_moves: assert property (@(posedge clk) disable iff (!arst_n)
		fire && sel_hit && !busy_q && !wrap_wr |=> sel_q != $past(sel_q))
		else $error("accepted select press did not move the selection");
`endif

endmodule

### rtl/core/flps_led.sv
// flps_led: one led lane: pending setting, active setting and phase countdown
// depends on flps_pkg
module flps_led #(
	parameter logic INIT_BLINK = 1'b0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  flps_pkg::post_t               post,
	input  logic [flps_pkg::DUTY_W-1:0]   base,
	input  logic [15:0]                   extra,
	output logic                          lit_next,
	output logic                          blink
);
	import flps_pkg::*;

	logic              pv_q, pb_q, ab_q, lit_q;
	logic [DUTY_W-1:0] pd_q, ad_q;
	logic [CD_W-1:0]   cd_q;

	logic              pv_m, pb_m, ab_n, start_lit;
	logic [DUTY_W-1:0] pd_m, ad_n;
	logic [CD_W-1:0]   off_cur, off_new, start_cd, cd_t, cd_d;
	logic              pv_d, ab_d;
	logic [DUTY_W-1:0] ad_d;

	assign blink = ab_q;

	always_comb begin
		pv_m    = pv_q | post.valid;
		pd_m    = post.valid ? post.duty : pd_q;
		pb_m    = post.valid ? post.blink : pb_q;
		ad_n    = pv_m ? pd_m : ad_q;
		ab_n    = pv_m ? pb_m : ab_q;
		off_cur = off_len(ad_q, ab_q, base, extra);
		off_new = off_len(ad_n, ab_n, base, extra);
		// period start: lit for duty, else dark for at least one tick
		start_lit = (ad_n != '0);
		if (start_lit)
			start_cd = {{(CD_W-DUTY_W){1'b0}}, ad_n};
		else
			start_cd = (off_new == '0) ? CD_W'(1) : off_new;

		lit_next = lit_q;
		cd_t     = cd_q;
		pv_d     = pv_m;
		ad_d     = ad_q;
		ab_d     = ab_q;
		if (cd_q == '0) begin
			if (lit_q && off_cur != '0) begin
				lit_next = 1'b0;
				cd_t     = off_cur;
			end else begin
				lit_next = start_lit;
				cd_t     = start_cd;
				pv_d     = 1'b0;
				ad_d     = ad_n;
				ab_d     = ab_n;
			end
		end
		cd_d = cd_t - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q  <= 1'b0;
			ad_q  <= '0;
			ab_q  <= INIT_BLINK;
			lit_q <= 1'b0;
			cd_q  <= '0;
		end else if (fire) begin
			pv_q  <= pv_d;
			ad_q  <= ad_d;
			ab_q  <= ab_d;
			lit_q <= lit_next;
			cd_q  <= cd_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pd_q <= pd_m;
			pb_q <= pb_m;
		end
	end

endmodule

### rtl/core/four_led_pwm_selector.sv
// four_led_pwm_selector: top level, input register, result register and lane array
// depends on flps_pkg, flps_cfg, flps_ctrl, flps_led
//
// usage:
//   in channel (in_valid/in_ready) takes one beat per millisecond tick: the button
//   interrupt flag and the two button levels. out channel (out_valid/out_ready)
//   returns one beat per tick: the led levels and the selected led index.
//   an accepted beat passes the input register, then the result register. one
//   beat is taken every cycle unless stalled, set by the single pass from the input
//   register through the debounce, select and lane update logic into the result
//   register. a stalled receiver holds the result register; one more beat waits
//   in the input register, then in_ready drops until the result is taken.
//   registers sit on the apb port at byte addresses 0, 4, 8 and 12 (gap, base,
//   wrap, extra). a write to the wrap register starts a residue sweep
//   during which in_ready is low; write configuration only while no beat is
//   in flight.
//   reset clears counters and duties and loads the default settings; led 0 starts selected with blink set.
module four_led_pwm_selector #(
	parameter int NUM_LEDS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [3:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        button_irq,
	input  logic                        select_pressed,
	input  logic                        step_pressed,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [NUM_LEDS-1:0]         led_levels,
	output logic [$clog2(NUM_LEDS)-1:0] selected_led
);
	import flps_pkg::*;

	localparam int SEL_W = $clog2(NUM_LEDS);

	cfg_t                   cfg;
	logic                   wrap_wr, sweep_busy, fire;
	logic                   valid_s1, irq_s1, sel_s1, stp_s1;
	post_t [NUM_LEDS-1:0]   posts;
	logic [NUM_LEDS-1:0]    act_blink, lit_next;
	logic [SEL_W-1:0]       sel_next;
	logic                   out_valid_q;
	logic [NUM_LEDS-1:0]    levels_q;
	logic [SEL_W-1:0]       sel_led_q;

	assign fire         = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready     = (!valid_s1 || fire) && !sweep_busy && !wrap_wr;
	assign out_valid    = out_valid_q;
	assign led_levels   = levels_q;
	assign selected_led = sel_led_q;

	flps_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.wrap_wr (wrap_wr)
	);

	flps_ctrl #(
		.NUM_LEDS (NUM_LEDS),
		.SEL_W    (SEL_W)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire),
		.button_irq     (irq_s1),
		.select_pressed (sel_s1),
		.step_pressed   (stp_s1),
		.cfg            (cfg),
		.wrap_wr        (wrap_wr),
		.act_blink      (act_blink),
		.posts          (posts),
		.sel_next       (sel_next),
		.busy           (sweep_busy)
	);

	for (genvar k = 0; k < NUM_LEDS; k++) begin : g_led
		flps_led #(
			.INIT_BLINK ((k == 0) ? 1'b1 : 1'b0)
		) u_led (
			.clk      (clk),
			.arst_n   (arst_n),
			.fire     (fire),
			.post     (posts[k]),
			.base     (cfg.base),
			.extra    (cfg.extra),
			.lit_next (lit_next[k]),
			.blink    (act_blink[k])
		);
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_valid && in_ready)
			valid_s1 <= 1'b1;
		else if (fire)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			irq_s1 <= button_irq;
			sel_s1 <= select_pressed;
			stp_s1 <= step_pressed;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fire)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			levels_q  <= lit_next;
			sel_led_q <= sel_next;
		end
	end

`ifndef SYNTHESIS
	a_sweep_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_busy |-> !in_ready)
		else $error("input beat offered acceptance during residue sweep");
	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("processed beat produced no result");
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(irq_s1) && $stable(sel_s1)
			&& $stable(stp_s1))
		else $error("waiting input beat lost or changed");
	a_sweep_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sweep_busy) |-> $past(wrap_wr))
		else $error("residue sweep started without a wrap write");
`endif

endmodule
